// ===== src/lfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfr_pkg
// shared types and constants of the learning frame router
// ----------------------------------------------------------------------------
package lfr_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_HUB_ADDR      = 3'd0;
    localparam logic [2:0] CFG_BCAST_ADDR    = 3'd1;
    localparam logic [2:0] CFG_UNASG_ADDR    = 3'd2;
    localparam logic [2:0] CFG_ROUTE_TIMEOUT = 3'd3;
    localparam logic [2:0] CFG_PING_THROTTLE = 3'd4;

    // configuration reset values
    localparam logic [7:0]  HUB_ADDR_RST      = 8'd1;
    localparam logic [7:0]  BCAST_ADDR_RST    = 8'd255;
    localparam logic [7:0]  UNASG_ADDR_RST    = 8'd0;
    localparam logic [31:0] ROUTE_TIMEOUT_RST = 32'd15000;
    localparam logic [31:0] PING_THROTTLE_RST = 32'd500;

    // ingress code of hub-originated frames and the no-exception code
    localparam logic [2:0] HUB_ORIGIN = 3'd4;
    localparam logic [2:0] NO_EXCEPT  = 3'd4;

    typedef enum logic [1:0] {
        DEC_LOCAL   = 2'd0,
        DEC_FLOOD   = 2'd1,
        DEC_FWD     = 2'd2,
        DEC_NOROUTE = 2'd3
    } dec_t;

    typedef enum logic [2:0] {
        CLS_ECHO,
        CLS_HUB,
        CLS_HEART,
        CLS_BCAST,
        CLS_UNI
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LRN_WALK,
        ST_LRN_WR,
        ST_RT_WALK,
        ST_PING,
        ST_FIN
    } state_t;

    // one learned route
    typedef struct packed {
        logic [7:0]  addr;
        logic [1:0]  link;
        logic [31:0] stamp;
    } entry_t;

    // compare unit result
    typedef struct packed {
        logic hit;
        logic aged;
    } cmp_res_t;

endpackage

// ===== src/learning_frame_router.sv =====
// sequence: a frame that is neither learned nor unicast goes straight to the
//   result step; a learned source walks the route table and then writes it, and
//   a unicast frame walks it for a route and then takes the ping step; the walks
//   read one table entry per cycle; a new request is taken only when idle, and a
//   finished result waits in the output register while the next one is taken
// reset: synchronous; table valid bits and last ping time clear at once
// ----------------------------------------------------------------------------
// learning_frame_router
// source-learning frame router with route aging and throttled discovery pings
// ----------------------------------------------------------------------------
module learning_frame_router #(
    parameter int TABLE_ENTRIES = 16,
    parameter int LINK_COUNT    = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_src_addr,
    input  logic [7:0]  s_dst_addr,
    input  logic        s_heartbeat,
    input  logic [2:0]  s_ingress_link,
    input  logic [31:0] s_now_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_decision,
    output logic [1:0]  m_egress_link,
    output logic [2:0]  m_except_link,
    output logic        m_deliver_local,
    output logic        m_discovery_ping,
    output logic [7:0]  m_ping_target
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);

    // configuration
    logic [7:0]  hub_addr_reg;
    logic [7:0]  bcast_addr_reg;
    logic [7:0]  unasg_addr_reg;
    logic [31:0] timeout_reg;
    logic [31:0] throttle_reg;

    // sequencer
    lfr_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             eval_reg, eval_next;
    logic [IDX_W-1:0] eval_idx_reg, eval_idx_next;
    logic             walk_done;

    // captured request
    logic [7:0]    src_reg, src_next;
    logic [7:0]    dst_reg, dst_next;
    logic [2:0]    ing_reg, ing_next;
    logic [31:0]   now_reg, now_next;
    lfr_pkg::cls_t cls_reg, cls_next;
    logic          link_ok_reg, link_ok_next;

    // walk results
    logic             found_reg, found_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_slot_reg, free_slot_next;
    logic             hit_reg, hit_next;
    logic [1:0]       hit_link_reg, hit_link_next;
    logic             ping_fire_reg, ping_fire_next;

    // table and ping state
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]              last_ping_reg, last_ping_next;
    lfr_pkg::entry_t          mem [TABLE_ENTRIES];
    lfr_pkg::entry_t          rd_data_reg;
    logic                     rd_en;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    lfr_pkg::entry_t          mem_wdata;

    // output register
    logic           m_valid_reg, m_valid_next;
    lfr_pkg::dec_t  dec_reg, dec_next;
    logic [1:0]     olink_reg, olink_next;
    logic [2:0]     except_reg, except_next;
    logic           deliver_reg, deliver_next;
    logic           ping_out_reg, ping_out_next;
    logic [7:0]     target_reg, target_next;

    // request side decode
    logic          acc;
    logic          in_link_ok;
    logic          in_learnable;
    lfr_pkg::cls_t in_cls;
    logic          out_free;
    logic          ev_valid;

    // shared compare unit operands
    logic [7:0]        cmp_key;
    logic [31:0]       cmp_base;
    logic [31:0]       cmp_limit;
    lfr_pkg::cmp_res_t cmp_res;

    assign s_ready  = (state_reg == lfr_pkg::ST_IDLE);
    assign acc      = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign ev_valid = valid_reg[eval_idx_reg];
    assign walk_done = eval_reg && (iss_reg == LAST_CNT);

    // ingress link check and source learnability
    assign in_link_ok   = ({5'd0, s_ingress_link} < 8'(LINK_COUNT));
    assign in_learnable = (s_src_addr != unasg_addr_reg) && (s_src_addr != bcast_addr_reg) &&
                          (s_src_addr != hub_addr_reg) && in_link_ok;

    // frame class in priority order
    always_comb begin
        priority if (s_src_addr == hub_addr_reg && s_ingress_link != lfr_pkg::HUB_ORIGIN) begin
            in_cls = lfr_pkg::CLS_ECHO;
        end else if (s_dst_addr == hub_addr_reg) begin
            in_cls = lfr_pkg::CLS_HUB;
        end else if (s_heartbeat && s_src_addr != hub_addr_reg) begin
            in_cls = lfr_pkg::CLS_HEART;
        end else if (s_dst_addr == bcast_addr_reg) begin
            in_cls = lfr_pkg::CLS_BCAST;
        end else begin
            in_cls = lfr_pkg::CLS_UNI;
        end
    end

    // operand select for the shared compare unit
    assign cmp_key   = (state_reg == lfr_pkg::ST_LRN_WALK) ? src_reg : dst_reg;
    assign cmp_base  = (state_reg == lfr_pkg::ST_PING) ? last_ping_reg : rd_data_reg.stamp;
    assign cmp_limit = (state_reg == lfr_pkg::ST_PING) ? throttle_reg : timeout_reg;

    lfr_cmp_unit u_cmp (
        .key        (cmp_key),
        .entry_addr (rd_data_reg.addr),
        .now_ms     (now_reg),
        .base_ms    (cmp_base),
        .limit_ms   (cmp_limit),
        .res        (cmp_res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lfr_pkg::ST_IDLE: begin
                if (acc) begin
                    if (in_learnable) begin
                        state_next = lfr_pkg::ST_LRN_WALK;
                    end else if (in_cls == lfr_pkg::CLS_UNI) begin
                        state_next = lfr_pkg::ST_RT_WALK;
                    end else begin
                        state_next = lfr_pkg::ST_FIN;
                    end
                end
            end
            lfr_pkg::ST_LRN_WALK: begin
                if (walk_done) begin
                    state_next = lfr_pkg::ST_LRN_WR;
                end
            end
            lfr_pkg::ST_LRN_WR: begin
                state_next = (cls_reg == lfr_pkg::CLS_UNI) ? lfr_pkg::ST_RT_WALK
                                                           : lfr_pkg::ST_FIN;
            end
            lfr_pkg::ST_RT_WALK: begin
                if (walk_done) begin
                    state_next = lfr_pkg::ST_PING;
                end
            end
            lfr_pkg::ST_PING: begin
                state_next = lfr_pkg::ST_FIN;
            end
            lfr_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = lfr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lfr_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control per state
    always_comb begin
        iss_next        = iss_reg;
        eval_next       = eval_reg;
        eval_idx_next   = eval_idx_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        ing_next        = ing_reg;
        now_next        = now_reg;
        cls_next        = cls_reg;
        link_ok_next    = link_ok_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        hit_next        = hit_reg;
        hit_link_next   = hit_link_reg;
        ping_fire_next  = ping_fire_reg;
        valid_next      = valid_reg;
        last_ping_next  = last_ping_reg;
        rd_en           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = found_reg ? slot_reg : free_slot_reg;
        mem_wdata.addr  = src_reg;
        mem_wdata.link  = ing_reg[1:0];
        mem_wdata.stamp = now_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        dec_next        = dec_reg;
        olink_next      = olink_reg;
        except_next     = except_reg;
        deliver_next    = deliver_reg;
        ping_out_next   = ping_out_reg;
        target_next     = target_reg;

        unique case (state_reg)
            lfr_pkg::ST_IDLE: begin
                if (acc) begin
                    src_next        = s_src_addr;
                    dst_next        = s_dst_addr;
                    ing_next        = s_ingress_link;
                    now_next        = s_now_ms;
                    cls_next        = in_cls;
                    link_ok_next    = in_link_ok;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    hit_next        = 1'b0;
                    ping_fire_next  = 1'b0;
                    iss_next        = '0;
                    eval_next       = 1'b0;
                end
            end
            lfr_pkg::ST_LRN_WALK: begin
                // issue the next read, evaluate the previous one
                if (iss_reg != LAST_CNT) begin
                    rd_en         = 1'b1;
                    iss_next      = iss_reg + CNT_W'(1);
                    eval_next     = 1'b1;
                    eval_idx_next = iss_reg[IDX_W-1:0];
                end else begin
                    eval_next = 1'b0;
                end
                if (eval_reg) begin
                    if (ev_valid && cmp_res.hit && !found_reg) begin
                        found_next = 1'b1;
                        slot_next  = eval_idx_reg;
                    end
                    if (!ev_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_slot_next  = eval_idx_reg;
                    end
                end
            end
            lfr_pkg::ST_LRN_WR: begin
                // refresh a matching entry or fill the first free slot
                mem_we = found_reg || free_found_reg;
                if (!found_reg && free_found_reg) begin
                    valid_next[free_slot_reg] = 1'b1;
                end
                iss_next  = '0;
                eval_next = 1'b0;
            end
            lfr_pkg::ST_RT_WALK: begin
                if (iss_reg != LAST_CNT) begin
                    rd_en         = 1'b1;
                    iss_next      = iss_reg + CNT_W'(1);
                    eval_next     = 1'b1;
                    eval_idx_next = iss_reg[IDX_W-1:0];
                end else begin
                    eval_next = 1'b0;
                end
                // age out, then match the destination among the survivors
                if (eval_reg && ev_valid) begin
                    if (cmp_res.aged) begin
                        valid_next[eval_idx_reg] = 1'b0;
                    end else if (cmp_res.hit && !hit_reg) begin
                        hit_next      = 1'b1;
                        hit_link_next = rd_data_reg.link;
                    end
                end
            end
            lfr_pkg::ST_PING: begin
                // throttled discovery ping on a miss
                if (!hit_reg && cmp_res.aged) begin
                    ping_fire_next = 1'b1;
                    last_ping_next = now_reg;
                end
            end
            lfr_pkg::ST_FIN: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    dec_next      = lfr_pkg::DEC_LOCAL;
                    olink_next    = 2'd0;
                    except_next   = lfr_pkg::NO_EXCEPT;
                    deliver_next  = 1'b0;
                    ping_out_next = 1'b0;
                    target_next   = 8'd0;
                    unique case (cls_reg)
                        lfr_pkg::CLS_ECHO: begin
                            dec_next = lfr_pkg::DEC_LOCAL;
                        end
                        lfr_pkg::CLS_HUB: begin
                            deliver_next = 1'b1;
                        end
                        lfr_pkg::CLS_HEART: begin
                            dec_next = lfr_pkg::DEC_LOCAL;
                        end
                        lfr_pkg::CLS_BCAST: begin
                            dec_next    = lfr_pkg::DEC_FLOOD;
                            except_next = link_ok_reg ? ing_reg : lfr_pkg::NO_EXCEPT;
                        end
                        lfr_pkg::CLS_UNI: begin
                            if (hit_reg) begin
                                dec_next   = lfr_pkg::DEC_FWD;
                                olink_next = hit_link_reg;
                            end else begin
                                dec_next      = lfr_pkg::DEC_NOROUTE;
                                ping_out_next = ping_fire_reg;
                                target_next   = ping_fire_reg ? dst_reg : 8'd0;
                            end
                        end
                        default: begin
                            dec_next = lfr_pkg::DEC_LOCAL;
                        end
                    endcase
                end
            end
            default: begin
                eval_next = 1'b0;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= lfr_pkg::ST_IDLE;
            iss_reg        <= '0;
            eval_reg       <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            ping_fire_reg  <= 1'b0;
            valid_reg      <= '0;
            last_ping_reg  <= '0;
            m_valid_reg    <= 1'b0;
            hub_addr_reg   <= lfr_pkg::HUB_ADDR_RST;
            bcast_addr_reg <= lfr_pkg::BCAST_ADDR_RST;
            unasg_addr_reg <= lfr_pkg::UNASG_ADDR_RST;
            timeout_reg    <= lfr_pkg::ROUTE_TIMEOUT_RST;
            throttle_reg   <= lfr_pkg::PING_THROTTLE_RST;
        end else begin
            state_reg      <= state_next;
            iss_reg        <= iss_next;
            eval_reg       <= eval_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            hit_reg        <= hit_next;
            ping_fire_reg  <= ping_fire_next;
            valid_reg      <= valid_next;
            last_ping_reg  <= last_ping_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    lfr_pkg::CFG_HUB_ADDR:      hub_addr_reg   <= cfg_wdata[7:0];
                    lfr_pkg::CFG_BCAST_ADDR:    bcast_addr_reg <= cfg_wdata[7:0];
                    lfr_pkg::CFG_UNASG_ADDR:    unasg_addr_reg <= cfg_wdata[7:0];
                    lfr_pkg::CFG_ROUTE_TIMEOUT: timeout_reg    <= cfg_wdata;
                    lfr_pkg::CFG_PING_THROTTLE: throttle_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        eval_idx_reg  <= eval_idx_next;
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        ing_reg       <= ing_next;
        now_reg       <= now_next;
        cls_reg       <= cls_next;
        link_ok_reg   <= link_ok_next;
        slot_reg      <= slot_next;
        free_slot_reg <= free_slot_next;
        hit_link_reg  <= hit_link_next;
        dec_reg       <= dec_next;
        olink_reg     <= olink_next;
        except_reg    <= except_next;
        deliver_reg   <= deliver_next;
        ping_out_reg  <= ping_out_next;
        target_reg    <= target_next;
    end

    // route table memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[iss_reg[IDX_W-1:0]];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_decision       = dec_reg;
    assign m_egress_link    = olink_reg;
    assign m_except_link    = except_reg;
    assign m_deliver_local  = deliver_reg;
    assign m_discovery_ping = ping_out_reg;
    assign m_ping_target    = target_reg;

`ifndef ASSERT_OFF
    // a ping goes only with a missed unicast route
    a_ping_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_discovery_ping) |-> (m_decision == lfr_pkg::DEC_NOROUTE))
        else $error("discovery ping without a route miss");

    // hub delivery is always a local decision
    a_deliver_local: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_deliver_local) |-> (m_decision == lfr_pkg::DEC_LOCAL))
        else $error("hub delivery with non-local decision");

    // the table changes by at most one entry per cycle
    a_one_valid_change: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg ^ $past(valid_reg)) <= 1)
        else $error("more than one table entry changed in a cycle");

    // the ping time moves only out of the ping step
    a_ping_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_ping_reg != $past(last_ping_reg)) |-> ($past(state_reg) == lfr_pkg::ST_PING))
        else $error("last ping time changed outside the ping step");
`endif

endmodule

// ===== src/lfr_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// lfr_cmp_unit
// shared address match and wrapping age compare, used once per cycle
// ----------------------------------------------------------------------------
module lfr_cmp_unit (
    input  logic [7:0]       key,
    input  logic [7:0]       entry_addr,
    input  logic [31:0]      now_ms,
    input  logic [31:0]      base_ms,
    input  logic [31:0]      limit_ms,
    output lfr_pkg::cmp_res_t res
);

    logic [31:0] age;

    // age wraps modulo 2^32
    assign age      = now_ms - base_ms;
    assign res.hit  = (key == entry_addr);
    assign res.aged = (age >= limit_ms);

endmodule
